[sv/bu_pkg.sv]
package bu_pkg;

  // Default sizes of the tile store, of the largest enlargement and of the request queue.
  localparam int TILE_DIM_DEF       = 64;
  localparam int MAX_SCALE_LOG2_DEF = 4;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // Field widths of the channels and registers.
  localparam int ROW_W     = 10;
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 7;
  localparam int SCALE_W   = 3;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [DIM_W-1:0]   SRC_HEIGHT_RST     = 7'd64;
  localparam logic [DIM_W-1:0]   SRC_WIDTH_RST      = 7'd64;
  localparam logic [SCALE_W-1:0] SCALE_LOG2_RST     = 3'd3;
  localparam logic               VERTICAL_BLEND_RST = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_HEIGHT     = 2'd0,
    REG_SRC_WIDTH      = 2'd1,
    REG_SCALE_LOG2     = 2'd2,
    REG_VERTICAL_BLEND = 2'd3
  } cfg_reg_t;

  // Request kinds.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

[sv/bu_front.sv]
module bu_front import bu_pkg::*; #(
  parameter int TILE_DIM       = TILE_DIM_DEF,
  parameter int MAX_SCALE_LOG2 = MAX_SCALE_LOG2_DEF,
  parameter type entry_t       = logic
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [ROW_W-1:0]     in_col,
  input  logic [PIX_W-1:0]     in_pixel_in,
  input  logic                 q_full,
  output logic                 q_push,
  output entry_t               q_entry
);

  localparam int IW = $clog2(TILE_DIM);
  localparam int AW = $clog2(TILE_DIM * TILE_DIM);
  localparam int FW = MAX_SCALE_LOG2;
  localparam int WW = MAX_SCALE_LOG2 + 1;
  localparam int LW = (DIM_W + MAX_SCALE_LOG2 > ROW_W) ? DIM_W + MAX_SCALE_LOG2 : ROW_W;

  logic [DIM_W-1:0]   src_height_r;
  logic [DIM_W-1:0]   src_width_r;
  logic [SCALE_W-1:0] scale_log2_r;
  logic               vertical_blend_r;

  logic [SCALE_W-1:0] s_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [DIM_W-1:0]   w_eff;
  logic [LW-1:0]      lim_h;
  logic [LW-1:0]      lim_w;
  logic [WW-1:0]      k;
  logic [FW-1:0]      mask;
  logic [FW-1:0]      fx;
  logic [FW-1:0]      fy;
  logic [ROW_W-1:0]   ys_full;
  logic [ROW_W-1:0]   xs_full;
  logic [ROW_W:0]     ys_p1;
  logic [ROW_W:0]     xs_p1;
  logic [IW-1:0]      ys;
  logic [IW-1:0]      xs;
  logic [IW-1:0]      ys1;
  logic [IW-1:0]      xs1;
  logic               oor;
  logic               in_tile;

  function automatic logic [AW-1:0] tile_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(TILE_DIM) + AW'(c);
  endfunction

  // Configuration registers; to be written only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_height_r     <= SRC_HEIGHT_RST;
      src_width_r      <= SRC_WIDTH_RST;
      scale_log2_r     <= SCALE_LOG2_RST;
      vertical_blend_r <= VERTICAL_BLEND_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_HEIGHT:     src_height_r     <= cfg_data;
        REG_SRC_WIDTH:      src_width_r      <= cfg_data;
        REG_SCALE_LOG2:     scale_log2_r     <= cfg_data[SCALE_W-1:0];
        REG_VERTICAL_BLEND: vertical_blend_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective dimensions and scale, with zero and oversized values saturated.
  always_comb begin
    s_eff = (32'(scale_log2_r) > MAX_SCALE_LOG2) ? SCALE_W'(MAX_SCALE_LOG2) : scale_log2_r;
    if (src_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(src_height_r) > TILE_DIM) begin
      h_eff = DIM_W'(TILE_DIM);
    end else begin
      h_eff = src_height_r;
    end
    if (src_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(src_width_r) > TILE_DIM) begin
      w_eff = DIM_W'(TILE_DIM);
    end else begin
      w_eff = src_width_r;
    end
    lim_h = LW'(h_eff) << s_eff;
    lim_w = LW'(w_eff) << s_eff;
    k     = WW'(1) << s_eff;
    mask  = FW'(k - WW'(1));
  end

  // Source cell, clamped neighbors and fractional position of a query.
  always_comb begin
    oor     = (LW'(in_row) >= lim_h) || (LW'(in_col) >= lim_w);
    ys_full = in_row >> s_eff;
    xs_full = in_col >> s_eff;
    ys_p1   = {1'b0, ys_full} + (ROW_W+1)'(1);
    xs_p1   = {1'b0, xs_full} + (ROW_W+1)'(1);
    fx      = in_col[FW-1:0] & mask;
    fy      = vertical_blend_r ? (in_row[FW-1:0] & mask) : '0;
    if (oor) begin
      ys  = '0;
      xs  = '0;
      ys1 = '0;
      xs1 = '0;
    end else begin
      ys  = ys_full[IW-1:0];
      xs  = xs_full[IW-1:0];
      xs1 = (xs_p1 < (ROW_W+1)'(w_eff)) ? xs_p1[IW-1:0] : IW'(w_eff - DIM_W'(1));
      // Horizontal mode repeats the row, so the lower pair reads the same row.
      if (!vertical_blend_r) begin
        ys1 = ys_full[IW-1:0];
      end else if (ys_p1 < (ROW_W+1)'(h_eff)) begin
        ys1 = ys_p1[IW-1:0];
      end else begin
        ys1 = IW'(h_eff - DIM_W'(1));
      end
    end
  end

  // Loads outside the tile are dropped here and never reach the queue.
  assign in_tile  = (32'(in_row) < TILE_DIM) && (32'(in_col) < TILE_DIM);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && ((in_mode == MODE_QUERY) || in_tile);

  // Queue entry for the back end.
  always_comb begin
    q_entry = '0;
    q_entry.is_query = (in_mode == MODE_QUERY);
    q_entry.data     = in_pixel_in;
    q_entry.s        = s_eff;
    if (in_mode == MODE_QUERY) begin
      q_entry.oor    = oor;
      q_entry.addr_a = tile_addr(ys, xs);
      q_entry.addr_b = tile_addr(ys, xs1);
      q_entry.addr_c = tile_addr(ys1, xs);
      q_entry.addr_d = tile_addr(ys1, xs1);
      q_entry.wx0    = k - WW'(fx);
      q_entry.wx1    = WW'(fx);
      q_entry.wy0    = k - WW'(fy);
      q_entry.wy1    = WW'(fy);
    end else begin
      q_entry.addr_a = tile_addr(in_row[IW-1:0], in_col[IW-1:0]);
    end
  end

endmodule

[sv/bu_queue.sv]
module bu_queue import bu_pkg::*; #(
  parameter int  DEPTH   = QUEUE_DEPTH_DEF,
  parameter type entry_t = logic
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         slots_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW-1:0]  rd_ptr_nxt;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  // Pointers wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/bu_back.sv]
module bu_back import bu_pkg::*; #(
  parameter int TILE_DIM       = TILE_DIM_DEF,
  parameter int MAX_SCALE_LOG2 = MAX_SCALE_LOG2_DEF,
  parameter type entry_t       = logic
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  entry_t           q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_pixel_out,
  output logic             out_out_of_range
);

  localparam int DEPTH = TILE_DIM * TILE_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int WPW   = 2 * MAX_SCALE_LOG2 + 1;
  localparam int SUMW  = PIX_W + 2 * MAX_SCALE_LOG2;

  typedef enum logic {PH_TOP, PH_BOT} phase_t;

  logic [PIX_W-1:0]   tile_mem [DEPTH];

  phase_t             phase_r;
  phase_t             phase_nxt;
  logic               r_v_r;
  logic               r_v_nxt;
  logic               m_v_r;
  logic               m_v_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;

  logic [PIX_W-1:0]   rd_a_r;
  logic [PIX_W-1:0]   rd_b_r;
  logic [PIX_W-1:0]   top_a_r;
  logic [PIX_W-1:0]   top_b_r;
  logic [WPW-1:0]     w00_r;
  logic [WPW-1:0]     w01_r;
  logic [WPW-1:0]     w10_r;
  logic [WPW-1:0]     w11_r;
  logic               r_oor_r;
  logic [SCALE_W-1:0] r_s_r;
  logic [SUMW-1:0]    prod0_r;
  logic [SUMW-1:0]    prod1_r;
  logic [SUMW-1:0]    prod2_r;
  logic [SUMW-1:0]    prod3_r;
  logic               m_oor_r;
  logic [SCALE_W-1:0] m_s_r;
  logic [PIX_W-1:0]   out_pixel_r;
  logic [PIX_W-1:0]   out_pixel_nxt;
  logic               out_oor_r;

  logic               adv;
  logic               mem_we;
  logic               rd_en;
  logic [AW-1:0]      rd_addr_a;
  logic [AW-1:0]      rd_addr_b;
  logic [SUMW-1:0]    sum;
  logic [SUMW-1:0]    scaled;

  // The read and blend pipeline moves only when the output register can take a result.
  assign adv    = !out_valid_r || !out_stall;
  assign mem_we = q_valid && !q_head.is_query && (phase_r == PH_TOP);
  assign rd_en  = adv && q_valid && q_head.is_query;
  assign q_pop  = mem_we || ((phase_r == PH_BOT) && adv);

  // Upper neighbor pair first, lower pair in the PH_BOT phase.
  assign rd_addr_a = (phase_r == PH_TOP) ? q_head.addr_a : q_head.addr_c;
  assign rd_addr_b = (phase_r == PH_TOP) ? q_head.addr_b : q_head.addr_d;

  // Tile memory: one write port for loads, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tile_mem[q_head.addr_a] <= q_head.data;
    end
    if (rd_en) begin
      rd_a_r <= tile_mem[rd_addr_a];
      rd_b_r <= tile_mem[rd_addr_b];
    end
  end

  // Next state of the sequencer and the stage valid bits.
  always_comb begin
    phase_nxt     = phase_r;
    r_v_nxt       = r_v_r;
    m_v_nxt       = m_v_r;
    out_valid_nxt = out_valid_r;
    case (phase_r)
      PH_TOP: begin
        if (rd_en) begin
          phase_nxt = PH_BOT;
        end
      end
      PH_BOT: begin
        if (adv) begin
          phase_nxt = PH_TOP;
        end
      end
      default: phase_nxt = PH_TOP;
    endcase
    if (adv) begin
      r_v_nxt       = (phase_r == PH_BOT);
      m_v_nxt       = r_v_r;
      out_valid_nxt = m_v_r;
    end
  end

  // Weighted sum, divided by k*k; horizontal mode carries a vertical weight of k.
  always_comb begin
    sum           = prod0_r + prod1_r + prod2_r + prod3_r;
    scaled        = sum >> {m_s_r, 1'b0};
    out_pixel_nxt = m_oor_r ? '0 : scaled[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TOP;
      r_v_r       <= 1'b0;
      m_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      r_v_r       <= r_v_nxt;
      m_v_r       <= m_v_nxt;
      out_valid_r <= out_valid_nxt;
      // Lower read phase: keep the upper pair and form the corner weights.
      if ((phase_r == PH_BOT) && adv) begin
        top_a_r <= rd_a_r;
        top_b_r <= rd_b_r;
        w00_r   <= WPW'(q_head.wx0) * WPW'(q_head.wy0);
        w01_r   <= WPW'(q_head.wx1) * WPW'(q_head.wy0);
        w10_r   <= WPW'(q_head.wx0) * WPW'(q_head.wy1);
        w11_r   <= WPW'(q_head.wx1) * WPW'(q_head.wy1);
        r_oor_r <= q_head.oor;
        r_s_r   <= q_head.s;
      end
      // Pixel times weight, one product per neighbor.
      if (adv) begin
        prod0_r     <= SUMW'(top_a_r) * SUMW'(w00_r);
        prod1_r     <= SUMW'(top_b_r) * SUMW'(w01_r);
        prod2_r     <= SUMW'(rd_a_r) * SUMW'(w10_r);
        prod3_r     <= SUMW'(rd_b_r) * SUMW'(w11_r);
        m_oor_r     <= r_oor_r;
        m_s_r       <= r_s_r;
        out_pixel_r <= out_pixel_nxt;
        out_oor_r   <= m_oor_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pixel_r;
  assign out_out_of_range = out_oor_r;

endmodule

[sv/bilinear_upscaler.sv]
// Bilinear upscaler for an 8-bit grayscale tile enlarged by k = 2^scale_log2.
//
// Input channel (in_valid / in_stall): a load request (in_mode = 0) writes one
// source pixel; a query request (in_mode = 1) asks for one output pixel.
// Loads produce no result, and loads outside the tile are dropped. Each query
// produces exactly one result on the output channel (out_valid / out_stall),
// in request order: the blended pixel, or zero with out_out_of_range set.
// Configuration registers are to be written through cfg_we / cfg_index / cfg_data
// only while no request is in flight; the block itself does not enforce this.
//
// A query reads the upper neighbor pair and then the lower pair through the
// two tile memory read ports, so a new query starts only once the lower pair of
// the last one is read; a load uses only the write port. A result passes through
// the read, product and output registers. A small request queue separates the
// front end from the memory sequencer, so requests are taken while results wait.
// When out_stall is high a presented result holds and queries freeze, though
// loads still reach the tile; in_stall rises once the queue is full. Reset
// empties the queue and pipeline and loads the register defaults; the tile
// memory is not cleared and every entry must be loaded before a query reads it.
module bilinear_upscaler import bu_pkg::*; #(
  parameter int TILE_DIM       = TILE_DIM_DEF,
  parameter int MAX_SCALE_LOG2 = MAX_SCALE_LOG2_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [ROW_W-1:0]     in_col,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_out_of_range
);

  localparam int AW = $clog2(TILE_DIM * TILE_DIM);
  localparam int WW = MAX_SCALE_LOG2 + 1;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic               is_query;
    logic               oor;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    logic [AW-1:0]      addr_c;
    logic [AW-1:0]      addr_d;
    logic [PIX_W-1:0]   data;
    logic [SCALE_W-1:0] s;
    logic [WW-1:0]      wx0;
    logic [WW-1:0]      wx1;
    logic [WW-1:0]      wy0;
    logic [WW-1:0]      wy1;
  } bu_entry_t;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;
  bu_entry_t q_entry;
  bu_entry_t q_head;

  bu_front #(
    .TILE_DIM       (TILE_DIM),
    .MAX_SCALE_LOG2 (MAX_SCALE_LOG2),
    .entry_t        (bu_entry_t)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_pixel_in (in_pixel_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  bu_queue #(
    .DEPTH   (QUEUE_DEPTH),
    .entry_t (bu_entry_t)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bu_back #(
    .TILE_DIM       (TILE_DIM),
    .MAX_SCALE_LOG2 (MAX_SCALE_LOG2),
    .entry_t        (bu_entry_t)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_out_of_range (out_out_of_range)
  );

endmodule

[sv/bu_checker.sv]
module bu_checker import bu_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_pixel_out,
  input logic             out_out_of_range
);

  // A stalled result stays presented with the same payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) && $stable(out_out_of_range))
    else $error("stalled result changed or was dropped");

  // An out-of-range query always reports a zero pixel.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_pixel_out == '0)
    else $error("out-of-range result with nonzero pixel");

  // Reset empties the result pipeline.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // Reset empties the request queue, so requests are taken at once.
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind bilinear_upscaler bu_checker u_bu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pixel_out    (out_pixel_out),
  .out_out_of_range (out_out_of_range)
);

[verif/bilinear_upscaler_tb.sv]
`timescale 1ns / 100ps

module bilinear_upscaler_tb;
  import bu_pkg::*;

  localparam int TILE_DIM        = TILE_DIM_DEF;
  localparam int MAX_SCALE       = MAX_SCALE_LOG2_DEF;
  localparam int PHASE_COUNT     = 13;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int SETTLE_CYCLES   = 24;
  localparam int DRAIN_CYCLES    = 32;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int REPORT_LIMIT    = 10;
  localparam int DIR_STEPS       = 27;

  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             oor;
  } pixel_result_t;

  typedef struct packed {
    step_kind_t       kind;
    logic             mode;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [PIX_W-1:0] pix;
    cfg_reg_t         reg_sel;
    logic [CFG_W-1:0] reg_val;
    logic             typed;
    logic [PIX_W-1:0] want_pix;
    logic             want_oor;
  } dir_step_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_mode;
  logic [ROW_W-1:0]     in_row;
  logic [ROW_W-1:0]     in_col;
  logic [PIX_W-1:0]     in_pixel_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_out_of_range;

  // Shadow copy of the tile and of the registers, updated as loads are accepted and registers written.
  logic [PIX_W-1:0]   tile_shadow [TILE_DIM*TILE_DIM];
  logic [DIM_W-1:0]   shadow_height = SRC_HEIGHT_RST;
  logic [DIM_W-1:0]   shadow_width  = SRC_WIDTH_RST;
  logic [SCALE_W-1:0] shadow_scale  = SCALE_LOG2_RST;
  logic               shadow_vblend = VERTICAL_BLEND_RST;

  pixel_result_t awaited_pixels [$];
  int fault_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;

  // Directed requests. Rows with typed set carry an expected result that is
  // obvious by inspection; all other queries go through the predictor.
  dir_step_t dir_table [DIR_STEPS] = '{
    // A 2x2 corner block with one bright pixel.
    '{STEP_REQ, MODE_LOAD,     0,    0, 255, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_LOAD,     0,    1,   0, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_LOAD,     1,    0,   0, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_LOAD,     1,    1,   0, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_QUERY,    0,    0,   0, REG_SRC_HEIGHT,     0, 1, 255, 0},
    '{STEP_REQ, MODE_QUERY,    0,    4,   0, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_QUERY,    4,    4,   0, REG_SRC_HEIGHT,     0, 0,   0, 0},
    // Last row, then loads past the tile edge that must be dropped.
    '{STEP_REQ, MODE_LOAD,    63,    0,  10, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_LOAD,    63,    1,  20, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_LOAD,    63,   63,  77, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_LOAD,  1023,    0, 200, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_LOAD,    63,   64, 201, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_QUERY,  504,    0,   0, REG_SRC_HEIGHT,     0, 1,  10, 0},
    '{STEP_REQ, MODE_QUERY,  504,    4,   0, REG_SRC_HEIGHT,     0, 0,   0, 0},
    // Bottom right corner clamps both neighbours.
    '{STEP_REQ, MODE_QUERY,  511,  511,   0, REG_SRC_HEIGHT,     0, 1,  77, 0},
    // Queries just past and far past the enlarged area.
    '{STEP_REQ, MODE_QUERY,  512,    0,   0, REG_SRC_HEIGHT,     0, 1,   0, 1},
    '{STEP_REQ, MODE_QUERY, 1023, 1023,   0, REG_SRC_HEIGHT,     0, 1,   0, 1},
    '{STEP_REQ, MODE_QUERY,    0,  512,   0, REG_SRC_HEIGHT,     0, 1,   0, 1},
    // Horizontal blend with row repeat.
    '{STEP_CFG, MODE_LOAD,     0,    0,   0, REG_VERTICAL_BLEND, 0, 0,   0, 0},
    '{STEP_REQ, MODE_QUERY,    0,    4,   0, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_QUERY,    7,    0,   0, REG_SRC_HEIGHT,     0, 1, 255, 0},
    // No enlargement.
    '{STEP_CFG, MODE_LOAD,     0,    0,   0, REG_SCALE_LOG2,     0, 0,   0, 0},
    '{STEP_REQ, MODE_QUERY,    0,    0,   0, REG_SRC_HEIGHT,     0, 1, 255, 0},
    '{STEP_REQ, MODE_QUERY,   64,    0,   0, REG_SRC_HEIGHT,     0, 1,   0, 1},
    // Scale above the limit saturates, so the whole row range is in the area.
    '{STEP_CFG, MODE_LOAD,     0,    0,   0, REG_SCALE_LOG2,     7, 0,   0, 0},
    '{STEP_REQ, MODE_QUERY, 1023,    0,   0, REG_SRC_HEIGHT,     0, 0,   0, 0},
    '{STEP_REQ, MODE_QUERY,    0,   15,   0, REG_SRC_HEIGHT,     0, 0,   0, 0}
  };

  bilinear_upscaler uut (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > TILE_DIM) return TILE_DIM;
    return v;
  endfunction

  function automatic int unsigned eff_scale(input int unsigned v);
    return (v > MAX_SCALE) ? MAX_SCALE : v;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Expected output pixel of a query under the current shadow registers.
  function automatic pixel_result_t blend_pixel(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] col);
    int unsigned h, w, s, k, ys, xs, ys1, xs1, fy, fx, acc;
    pixel_result_t res;
    h = eff_dim(shadow_height);
    w = eff_dim(shadow_width);
    s = eff_scale(shadow_scale);
    k = 1 << s;
    res = '0;
    if (row >= (h << s) || col >= (w << s)) begin
      res.oor = 1'b1;
    end else begin
      ys  = row >> s;
      xs  = col >> s;
      fy  = row & (k - 1);
      fx  = col & (k - 1);
      ys1 = (ys + 1 < h) ? ys + 1 : h - 1;
      xs1 = (xs + 1 < w) ? xs + 1 : w - 1;
      if (shadow_vblend) begin
        acc = tile_shadow[ys*TILE_DIM + xs] * (k - fx) * (k - fy)
            + tile_shadow[ys*TILE_DIM + xs1] * fx * (k - fy)
            + tile_shadow[ys1*TILE_DIM + xs] * (k - fx) * fy
            + tile_shadow[ys1*TILE_DIM + xs1] * fx * fy;
        acc = acc >> (2 * s);
      end else begin
        acc = tile_shadow[ys*TILE_DIM + xs] * (k - fx) + tile_shadow[ys*TILE_DIM + xs1] * fx;
        acc = acc >> s;
      end
      res.pix = acc[PIX_W-1:0];
    end
    return res;
  endfunction

  // Drives one request in bursts with random gaps, waits until it is taken,
  // then records its effect on the shadow tile or its expected result.
  task automatic send_request(input logic mode, input logic [ROW_W-1:0] row,
                              input logic [ROW_W-1:0] col, input logic [PIX_W-1:0] pix,
                              input logic typed = 1'b0, input pixel_result_t want = '0);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_row      <= row;
    in_col      <= col;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (typed) begin
      awaited_pixels.push_back(want);
    end else if (mode == MODE_QUERY) begin
      awaited_pixels.push_back(blend_pixel(row, col));
    end else if (row < TILE_DIM && col < TILE_DIM) begin
      tile_shadow[row*TILE_DIM + col] = pix;
    end
  endtask

  // Register write once every query has been answered and trailing loads settled.
  task automatic write_register(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_SRC_HEIGHT:     shadow_height = val[DIM_W-1:0];
      REG_SRC_WIDTH:      shadow_width  = val[DIM_W-1:0];
      REG_SCALE_LOG2:     shadow_scale  = val[SCALE_W-1:0];
      REG_VERTICAL_BLEND: shadow_vblend = val[0];
      default: ;
    endcase
  endtask

  // One setting of the registers, a loaded window of the tile, then mixed traffic.
  task automatic run_phase(input int phase);
    int unsigned h, w, s, vb, eh, ew, es, span_r, span_c, r0, c0, r1, c1, rq_hi, cq_hi;
    int unsigned counted, pick, ys, xs;
    logic [ROW_W-1:0] row, col;
    logic [CFG_W-1:0] reg_val;
    logic             mode;
    case (phase)
      0: begin h = 1;   w = 1;   s = 0; vb = 1; end
      1: begin h = 64;  w = 64;  s = 4; vb = 1; end
      2: begin h = 0;   w = 127; s = 7; vb = 0; end
      3: begin h = 127; w = 0;   s = 5; vb = 1; end
      4: begin h = 64;  w = 1;   s = 2; vb = 0; end
      default: begin
        h  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 10);
        w  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 10);
        s  = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        vb = $urandom_range(0, 1);
      end
    endcase
    write_register(REG_SRC_HEIGHT, CFG_W'(h));
    write_register(REG_SRC_WIDTH, CFG_W'(w));
    // Unused upper data bits carry noise on the narrow registers.
    reg_val = CFG_W'($urandom_range(0, 127));
    reg_val[SCALE_W-1:0] = s[SCALE_W-1:0];
    write_register(REG_SCALE_LOG2, reg_val);
    reg_val = CFG_W'($urandom_range(0, 127));
    reg_val[0] = vb[0];
    write_register(REG_VERTICAL_BLEND, reg_val);

    eh = eff_dim(shadow_height);
    ew = eff_dim(shadow_width);
    es = eff_scale(shadow_scale);

    // Pick a window at least two cells wide where the tile allows it, often
    // against the lower or right edge so that clamping is exercised.
    span_r = $urandom_range(2, 6);
    if (span_r > eh) span_r = eh;
    span_c = $urandom_range(2, 6);
    if (span_c > ew) span_c = ew;
    r0 = ($urandom_range(0, 2) == 0) ? eh - span_r : $urandom_range(0, eh - span_r);
    c0 = ($urandom_range(0, 2) == 0) ? ew - span_c : $urandom_range(0, ew - span_c);
    r1 = r0 + span_r - 1;
    c1 = c0 + span_c - 1;
    // Query cells whose right and lower neighbours lie inside the window.
    rq_hi = (r1 == eh - 1) ? r1 : r1 - 1;
    cq_hi = (c1 == ew - 1) ? c1 : c1 - 1;

    for (ys = r0; ys <= r1; ys++) begin
      for (xs = c0; xs <= c1; xs++) begin
        send_request(MODE_LOAD, ROW_W'(ys), ROW_W'(xs), rand_pixel());
      end
    end

    counted = 0;
    while (counted < ITEMS_PER_PHASE) begin
      pick = $urandom_range(0, 99);
      ys   = $urandom_range(r0, rq_hi);
      xs   = $urandom_range(c0, cq_hi);
      mode = MODE_QUERY;
      row  = ROW_W'((ys << es) | $urandom_range(0, (1 << es) - 1));
      col  = ROW_W'((xs << es) | $urandom_range(0, (1 << es) - 1));
      if (pick >= 60 && pick < 75) begin
        // Overwrite a cell of the window.
        mode = MODE_LOAD;
        row  = ROW_W'($urandom_range(r0, r1));
        col  = ROW_W'($urandom_range(c0, c1));
      end else if (pick >= 75 && pick < 83) begin
        // Load anywhere inside the tile.
        mode = MODE_LOAD;
        row  = ROW_W'($urandom_range(0, TILE_DIM - 1));
        col  = ROW_W'($urandom_range(0, TILE_DIM - 1));
      end else if (pick >= 83 && pick < 92) begin
        // Query outside the enlarged area when one exists.
        if ((eh << es) <= 1023 && ($urandom_range(0, 1) == 0 || (ew << es) > 1023)) begin
          row = ROW_W'($urandom_range(eh << es, 1023));
          col = ROW_W'($urandom_range(0, 1023));
        end else if ((ew << es) <= 1023) begin
          row = ROW_W'($urandom_range(0, 1023));
          col = ROW_W'($urandom_range(ew << es, 1023));
        end
      end else if (pick >= 92) begin
        // Load past the tile edge, which the block drops.
        mode = MODE_LOAD;
        row  = ROW_W'($urandom_range(0, 1023));
        col  = ROW_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 1) == 0) row = ROW_W'($urandom_range(TILE_DIM, 1023));
        else col = ROW_W'($urandom_range(TILE_DIM, 1023));
      end
      send_request(mode, row, col, rand_pixel());
      if (pick < 92) counted++;
    end
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Result checker: each accepted result against the oldest pending expectation.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_pixels.size() == 0) begin
        note_fault($sformatf("result with no query pending: pixel %0d oor %0b",
                             out_pixel_out, out_out_of_range));
      end else begin
        want = awaited_pixels.pop_front();
        if (out_pixel_out !== want.pix)
          note_fault($sformatf("pixel_out expected %0d, got %0d", want.pix, out_pixel_out));
        if (out_out_of_range !== want.oor)
          note_fault($sformatf("out_of_range expected %0b, got %0b",
                               want.oor, out_out_of_range));
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side back-pressure, changing style every segment.
  initial begin
    stall_style_t style;
    int seg;
    int tick;
    out_stall = 1'b0;
    tick = 0;
    wait (rst_n === 1'b1);
    forever begin
      style = stall_style_t'($urandom_range(0, 3));
      seg   = $urandom_range(16, 200);
      repeat (seg) begin
        @(negedge clk);
        tick++;
        case (style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // Reset, directed requests, random phases, then drain and report.
  initial begin
    dir_step_t     step;
    pixel_result_t want;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_SRC_HEIGHT;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_mode     = MODE_LOAD;
    in_row      = '0;
    in_col      = '0;
    in_pixel_in = '0;
    for (int i = 0; i < TILE_DIM*TILE_DIM; i++) tile_shadow[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_STEPS; i++) begin
      step = dir_table[i];
      if (step.kind == STEP_CFG) begin
        write_register(step.reg_sel, step.reg_val);
      end else begin
        want.pix = step.want_pix;
        want.oor = step.want_oor;
        send_request(step.mode, step.row, step.col, step.pix, step.typed, want);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) run_phase(p);

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/bu_pkg.sv
sv/bu_front.sv
sv/bu_queue.sv
sv/bu_back.sv
sv/bilinear_upscaler.sv
sv/bu_checker.sv
verif/bilinear_upscaler_tb.sv
